/* design/pfba_pkg.sv */
// Package: shared constants and command codes of the page frame bitmap allocator
`default_nettype none
package pfba_pkg;
	localparam int NUM_PAGES_DEF = 4096;
	localparam int CNT_W         = 13;
	localparam int PAGE_W        = 12;
	localparam logic [CNT_W-1:0] CNT_MAX = 13'h1FFF;
	localparam logic [CNT_W-1:0] TOTAL_RST = 13'h1000;

	localparam logic [2:0] CMD_ALLOC     = 3'd0;
	localparam logic [2:0] CMD_LOCK      = 3'd1;
	localparam logic [2:0] CMD_FREE      = 3'd2;
	localparam logic [2:0] CMD_RESERVE   = 3'd3;
	localparam logic [2:0] CMD_UNRESERVE = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_OOM   = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
endpackage
`default_nettype wire

/* design/page_frame_bitmap_allocator_unit.sv */
// Top level: bitmap page frame allocator with next-fit search over a busy-bit memory
//
// channel   direction  handshake            word
// command   in         start & !busy        command, start_page, page_span
// config    in         cfg_valid&cfg_ready  cfg_data (total_pages)
// result    out        done strobe, 1 cycle result_page, status, counts
//
// After reset a clearing pass sweeps the busy memory, one page a cycle, with
// busy high. Each command then walks the memory one page at a time (read,
// then modify and write back); an allocation marks the found run one page
// a cycle. A zero span or unknown command goes straight to the result word.
// The next command can be taken at the edge that takes the result word.
// The result cannot be stalled.
`default_nettype none
module page_frame_bitmap_allocator_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [2:0]                 command,
	input  wire logic [pfba_pkg::PAGE_W-1:0] start_page,
	input  wire logic [pfba_pkg::CNT_W-1:0] page_span,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [pfba_pkg::CNT_W-1:0] cfg_data,
	output logic                            done,
	output logic [pfba_pkg::PAGE_W-1:0]     result_page,
	output logic [1:0]                      status,
	output logic [pfba_pkg::CNT_W-1:0]      used_pages,
	output logic [pfba_pkg::CNT_W-1:0]      reserved_pages,
	output logic [pfba_pkg::CNT_W-1:0]      avail_pages
);
	localparam int NUM_PAGES = pfba_pkg::NUM_PAGES_DEF;
	localparam int AW = $clog2(NUM_PAGES);
	localparam int PW = AW + 1;   // page number that can hold NUM_PAGES
	localparam int CW = pfba_pkg::CNT_W;

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_MOD   = 3'd3;
	localparam logic [2:0] S_MARK  = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0]    state_q;
	logic [2:0]    cmd_q;
	logic [PW-1:0] pg_q;        // current page
	logic [PW-1:0] run_start_q; // allocation run start
	logic [CW-1:0] left_q;      // pages still to handle / run still needed
	logic [CW-1:0] cnt_q;       // page count of the command
	logic [PW-1:0] hint_q;
	logic [CW-1:0] used_q;
	logic [CW-1:0] rsv_q;
	logic [CW-1:0] total_q;
	logic [1:0]    st_q;

	// busy memory
	logic          mem [NUM_PAGES];
	logic          rd_q;
	logic          we;
	logic [AW-1:0] waddr;
	logic          wdata;

	// effective total
	logic [PW-1:0] eff;
	always_comb begin
		if (total_q > PW'(NUM_PAGES))
			eff = PW'(NUM_PAGES);
		else
			eff = PW'(total_q);
	end

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !start;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_q <= mem[pg_q[AW-1:0]];
	end

	// write port selection
	logic is_set;
	assign is_set = (cmd_q == pfba_pkg::CMD_LOCK) || (cmd_q == pfba_pkg::CMD_RESERVE);
	logic in_rng;
	assign in_rng = pg_q < eff;
	always_comb begin
		we    = 1'b0;
		waddr = pg_q[AW-1:0];
		wdata = 1'b0;
		case (state_q)
			S_CLR: begin
				we = 1'b1;
			end
			S_MOD: begin
				if (cmd_q != pfba_pkg::CMD_ALLOC && in_rng && (rd_q != is_set)) begin
					we    = 1'b1;
					wdata = is_set;
				end
			end
			S_MARK: begin
				we    = 1'b1;
				wdata = 1'b1;
			end
			default: ;
		endcase
	end

	function automatic logic [CW-1:0] c_inc(input logic [CW-1:0] c, input logic [CW-1:0] n);
		logic [CW:0] s;
		s = {1'b0, c} + {1'b0, n};
		return s[CW] ? pfba_pkg::CNT_MAX : s[CW-1:0];
	endfunction

	function automatic logic [CW-1:0] c_dec(input logic [CW-1:0] c);
		return (c == '0) ? c : c - 1'b1;
	endfunction

	logic [PW-1:0] pg_nx;
	assign pg_nx = pg_q + 1'b1;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			cmd_q       <= '0;
			pg_q        <= '0;
			run_start_q <= '0;
			left_q      <= '0;
			cnt_q       <= '0;
			hint_q      <= '0;
			used_q      <= '0;
			rsv_q       <= '0;
			total_q     <= pfba_pkg::TOTAL_RST;
			st_q        <= pfba_pkg::ST_OK;
			done        <= 1'b0;
			result_page <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				// sweep the busy memory clear
				S_CLR: begin
					if (pg_q == PW'(NUM_PAGES - 1)) begin
						state_q <= S_IDLE;
						pg_q    <= '0;
					end else
						pg_q <= pg_nx;
				end
				// take a command or a configuration word
				S_IDLE: begin
					if (cfg_valid && cfg_ready)
						total_q <= cfg_data;
					if (start) begin
						cmd_q  <= command;
						cnt_q  <= page_span;
						left_q <= page_span;
						st_q   <= pfba_pkg::ST_OK;
						result_page <= '0;
						if (command == pfba_pkg::CMD_ALLOC) begin
							pg_q        <= hint_q;
							run_start_q <= hint_q;
							if (page_span == '0)
								state_q <= S_FIN;
							else if (hint_q >= eff) begin
								hint_q  <= eff;
								st_q    <= pfba_pkg::ST_OOM;
								state_q <= S_FIN;
							end else
								state_q <= S_RD;
						end else if (command > pfba_pkg::CMD_UNRESERVE || page_span == '0)
							state_q <= S_FIN;
						else begin
							pg_q    <= PW'(start_page);
							state_q <= S_RD;
						end
					end
				end
				// wait for the read of the current page
				S_RD: begin
					state_q <= S_MOD;
				end
				// modify the page just read and advance
				S_MOD: begin
					if (cmd_q == pfba_pkg::CMD_ALLOC) begin
						if (!rd_q && left_q == CW'(1)) begin
							hint_q      <= run_start_q;
							used_q      <= c_inc(used_q, cnt_q);
							result_page <= run_start_q[pfba_pkg::PAGE_W-1:0];
							pg_q        <= run_start_q;
							left_q      <= cnt_q;
							state_q     <= S_MARK;
						end else begin
							if (rd_q) begin
								run_start_q <= pg_nx;
								left_q      <= cnt_q;
							end else
								left_q <= left_q - 1'b1;
							if (pg_nx >= eff) begin
								hint_q  <= eff;
								st_q    <= pfba_pkg::ST_OOM;
								state_q <= S_FIN;
							end else begin
								pg_q    <= pg_nx;
								state_q <= S_RD;
							end
						end
					end else begin
						if ((cmd_q == pfba_pkg::CMD_FREE || cmd_q == pfba_pkg::CMD_UNRESERVE)
						    && pg_q < hint_q)
							hint_q <= pg_q;
						if (!in_rng) begin
							st_q    <= pfba_pkg::ST_RANGE;
							state_q <= S_FIN;
						end else begin
							if (rd_q != is_set) begin
								case (cmd_q)
									pfba_pkg::CMD_LOCK:    used_q <= c_inc(used_q, CW'(1));
									pfba_pkg::CMD_RESERVE: rsv_q  <= c_inc(rsv_q, CW'(1));
									pfba_pkg::CMD_FREE:    used_q <= c_dec(used_q);
									default:               rsv_q  <= c_dec(rsv_q);
								endcase
							end
							left_q <= left_q - 1'b1;
							pg_q   <= pg_nx;
							state_q <= (left_q == CW'(1)) ? S_FIN : S_RD;
						end
					end
				end
				// set the busy bits of the found run, one a cycle
				S_MARK: begin
					pg_q   <= pg_nx;
					left_q <= left_q - 1'b1;
					if (left_q == CW'(1))
						state_q <= S_FIN;
				end
				// present the result word
				S_FIN: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// status and counts
	logic [CW:0] sum;
	assign sum            = {1'b0, used_q} + {1'b0, rsv_q};
	assign status         = st_q;
	assign used_pages     = used_q;
	assign reserved_pages = rsv_q;
	always_comb begin
		if (sum >= (CW+1)'(eff))
			avail_pages = '0;
		else
			avail_pages = CW'((CW+1)'(eff) - sum);
	end

	// a result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	// no command taken while sweeping after reset
	a_clr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> busy) else $error("idle during clear");
	// status of a result is a defined code
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == pfba_pkg::ST_OK || status == pfba_pkg::ST_OOM
		          || status == pfba_pkg::ST_RANGE)) else $error("bad status");
endmodule
`default_nettype wire
